[rtl/core/priority_alert_table_unit_macros.svh]
// Assertion macros for the priority alert table unit.
// Uses the clock and reset names of the including module; no other dependencies.
`ifndef PRIORITY_ALERT_TABLE_UNIT_MACROS_SVH
`define PRIORITY_ALERT_TABLE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define PAT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PAT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PAT_ASSERT(lbl, prop, msg)
`define PAT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/pat_pkg.sv]
// Shared types, action codes and helpers for the priority alert table unit.
// No dependencies.
package pat_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH     = 3'd0,
      ACT_TICK     = 3'd1,
      ACT_DISM_ID  = 3'd2,
      ACT_DISM_CAT = 3'd3,
      ACT_CLEAR    = 3'd4,
      ACT_LIST     = 3'd5,
      ACT_LIST_CAT = 3'd6,
      ACT_COUNT    = 3'd7
   } action_type;

   localparam int MAX_RESULTS = 16;

   typedef struct packed {
      logic [31:0] id;
      logic [1:0]  pri;
      logic [7:0]  cat;
      logic [15:0] msg;
      logic [15:0] age;
      logic [15:0] rem;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [31:0] alert_id;
      logic [1:0]  priority_out;
      logic [7:0]  category_out;
      logic [15:0] message_out;
      logic [15:0] age_out;
      logic [15:0] remaining_out;
      logic [4:0]  match_count;
      logic        found;
      logic        entry_present;
      logic        last;
   } rsp_type;

   function automatic logic [4:0] sat5(input logic [7:0] v);
      sat5 = (v > 8'd31) ? 5'd31 : v[4:0];
   endfunction

endpackage

[rtl/core/pat_ifs.sv]
// Request and response channel interfaces of the priority alert table unit.
// No dependencies.
interface pat_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [1:0]  priority_in;
   logic [7:0]  category_in;
   logic [15:0] message_in;
   logic [15:0] duration_ticks;
   logic [15:0] delta_ticks;
   logic [31:0] target_id;
   modport source (output valid, action, priority_in, category_in, message_in,
                   duration_ticks, delta_ticks, target_id, input ready);
   modport sink (input valid, action, priority_in, category_in, message_in,
                 duration_ticks, delta_ticks, target_id, output ready);
endinterface

interface pat_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] alert_id;
   logic [1:0]  priority_out;
   logic [7:0]  category_out;
   logic [15:0] message_out;
   logic [15:0] age_out;
   logic [15:0] remaining_out;
   logic [4:0]  match_count;
   logic        found;
   logic        entry_present;
   logic        last;
   modport source (output valid, alert_id, priority_out, category_out, message_out,
                   age_out, remaining_out, match_count, found, entry_present, last,
                   input ready);
   modport sink (input valid, alert_id, priority_out, category_out, message_out,
                 age_out, remaining_out, match_count, found, entry_present, last,
                 output ready);
endinterface

[rtl/core/pat_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

[rtl/core/pat_ctrl.sv]
// Sequencer of the alert table: scan, select and compaction passes over the slot RAM.
// Depends on pat_pkg, pat_ifs, pat_ram and the assertion macro header.
`include "priority_alert_table_unit_macros.svh"
module pat_ctrl
   import pat_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic          clock,
   input  logic          reset,
   pat_req_if.sink       req_port,
   input  logic [4:0]    cap_limit,
   output logic          res_valid,
   input  logic          res_ready,
   output rsp_type       res_data
);
   localparam int SLOTS = CAPACITY + 1;
   localparam int IW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_PUSHCHK = 6'b000010,
      ST_COUNT   = 6'b000100,
      ST_SELECT  = 6'b001000,
      ST_FILTER  = 6'b010000,
      ST_EMIT    = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   action_type  op_ff;
   logic [7:0]  cat_ff;
   logic [15:0] delta_ff;
   logic [31:0] target_ff;
   logic [CW-1:0] held_ff, ra_ff, wa_ff, cnt_ff, total_ff;
   logic [31:0] next_id_ff, push_id_ff;
   logic        d_vld_ff, best_vld_ff, found_ff;
   logic [IW-1:0] d_idx_ff, best_idx_ff;
   entry_type   best_ff;
   logic [SLOTS-1:0] used_ff;
   logic [4:0]  k_ff;
   rsp_type     res_ff;

   logic        req_fire, scan, scan_done, start, rd_en, ram_we, keep, eligible, better;
   logic        is_list, list_last;
   logic [IW-1:0] ram_waddr;
   entry_type   ent, mod_ent, new_ent, ram_wdata;
   logic [ENTRY_W-1:0] rd_data;
   logic [16:0] age_sum;
   int          lim, nlist;

   function automatic rsp_type status_rsp(input logic [31:0] id, input logic [4:0] cnt,
                                          input logic fnd);
      rsp_type r;
      r             = '0;
      r.alert_id    = id;
      r.match_count = cnt;
      r.found       = fnd;
      r.last        = 1'b1;
      return r;
   endfunction

   function automatic rsp_type entry_rsp(input entry_type e, input logic [4:0] cnt,
                                         input logic lst);
      rsp_type r;
      r               = '0;
      r.alert_id      = e.id;
      r.priority_out  = e.pri;
      r.category_out  = e.cat;
      r.message_out   = e.msg;
      r.age_out       = e.age;
      r.remaining_out = e.rem;
      r.match_count   = cnt;
      r.entry_present = 1'b1;
      r.last          = lst;
      return r;
   endfunction

   pat_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (rd_en),
      .rd_addr(ra_ff[IW-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      ent      = entry_type'(rd_data);
      req_fire = req_port.valid && (state_ff == ST_IDLE);
      scan     = (state_ff == ST_COUNT) || (state_ff == ST_SELECT) || (state_ff == ST_FILTER);
      rd_en    = scan && (ra_ff < held_ff);
      scan_done = scan && (ra_ff == held_ff) && !d_vld_ff;
      is_list  = (op_ff == ACT_LIST) || (op_ff == ACT_LIST_CAT);

      if (cap_limit == 5'd0) lim = 1;
      else if (int'(cap_limit) > CAPACITY) lim = CAPACITY;
      else lim = int'(cap_limit);
      nlist     = (int'(total_ff) > MAX_RESULTS) ? MAX_RESULTS : int'(total_ff);
      list_last = (int'(k_ff) + 1 == nlist);

      // tick: saturate age up, remaining down
      age_sum     = {1'b0, ent.age} + {1'b0, delta_ff};
      mod_ent     = ent;
      mod_ent.age = age_sum[16] ? 16'hFFFF : age_sum[15:0];
      mod_ent.rem = (ent.rem > delta_ff) ? ent.rem - delta_ff : 16'd0;

      case (op_ff)
         ACT_PUSH:     keep = (d_idx_ff != best_idx_ff);
         ACT_TICK:     keep = (mod_ent.rem != 16'd0);
         ACT_DISM_ID:  keep = !((ent.id == target_ff) && !found_ff);
         ACT_DISM_CAT: keep = (ent.cat != cat_ff);
         default:      keep = 1'b1;
      endcase

      eligible = (ent.rem != 16'd0) && ((op_ff != ACT_LIST_CAT) || (ent.cat == cat_ff));
      if (op_ff == ACT_PUSH) begin
         better = !best_vld_ff || (ent.pri < best_ff.pri) ||
                  ((ent.pri == best_ff.pri) && (ent.age > best_ff.age));
      end else begin
         better = eligible && !used_ff[d_idx_ff] &&
                  (!best_vld_ff || (ent.pri > best_ff.pri) ||
                   ((ent.pri == best_ff.pri) && (ent.age < best_ff.age)));
      end

      new_ent.id  = next_id_ff;
      new_ent.pri = req_port.priority_in;
      new_ent.cat = req_port.category_in;
      new_ent.msg = req_port.message_in;
      new_ent.age = 16'd0;
      new_ent.rem = req_port.duration_ticks;

      if (state_ff == ST_FILTER) begin
         ram_we    = d_vld_ff && keep;
         ram_waddr = wa_ff[IW-1:0];
         ram_wdata = (op_ff == ACT_TICK) ? mod_ent : ent;
      end else begin
         ram_we    = req_fire && (action_type'(req_port.action) == ACT_PUSH);
         ram_waddr = held_ff[IW-1:0];
         ram_wdata = new_ent;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (action_type'(req_port.action)) inside
                  ACT_PUSH: state_in = ST_PUSHCHK;
                  ACT_TICK, ACT_DISM_ID, ACT_DISM_CAT: state_in = ST_FILTER;
                  ACT_CLEAR: state_in = ST_EMIT;
                  default: state_in = ST_COUNT;
               endcase
            end
         end
         ST_PUSHCHK: state_in = (int'(held_ff) > lim) ? ST_SELECT : ST_EMIT;
         ST_COUNT: begin
            if (scan_done) begin
               state_in = ((op_ff == ACT_COUNT) || (cnt_ff == '0)) ? ST_EMIT : ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (scan_done) state_in = (op_ff == ACT_PUSH) ? ST_FILTER : ST_EMIT;
         end
         ST_FILTER: begin
            if (scan_done) state_in = (op_ff == ACT_PUSH) ? ST_PUSHCHK : ST_EMIT;
         end
         ST_EMIT: begin
            if (res_ready) state_in = (is_list && !res_ff.last) ? ST_SELECT : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      start = (state_in != state_ff) &&
              ((state_in == ST_COUNT) || (state_in == ST_SELECT) || (state_in == ST_FILTER));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         held_ff    <= '0;
         next_id_ff <= 32'd1;
         d_vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start) begin
            ra_ff       <= '0;
            wa_ff       <= '0;
            cnt_ff      <= '0;
            d_vld_ff    <= 1'b0;
            best_vld_ff <= 1'b0;
            found_ff    <= 1'b0;
         end else if (scan) begin
            if (rd_en) ra_ff <= ra_ff + 1'b1;
            d_vld_ff <= rd_en;
            d_idx_ff <= ra_ff[IW-1:0];
            if (d_vld_ff) begin
               if (state_ff == ST_COUNT && eligible) cnt_ff <= cnt_ff + 1'b1;
               if (state_ff == ST_SELECT && better) begin
                  best_vld_ff <= 1'b1;
                  best_ff     <= ent;
                  best_idx_ff <= d_idx_ff;
               end
               if (state_ff == ST_FILTER) begin
                  if (keep) wa_ff <= wa_ff + 1'b1;
                  else cnt_ff <= cnt_ff + 1'b1;
                  if (op_ff == ACT_DISM_ID && !keep) found_ff <= 1'b1;
               end
            end
         end

         if (req_fire) begin
            op_ff     <= action_type'(req_port.action);
            cat_ff    <= req_port.category_in;
            delta_ff  <= req_port.delta_ticks;
            target_ff <= req_port.target_id;
            used_ff   <= '0;
            k_ff      <= '0;
            res_ff    <= status_rsp(32'd0, 5'd0, 1'b0);
            unique case (action_type'(req_port.action))
               ACT_PUSH: begin
                  held_ff    <= held_ff + 1'b1;
                  next_id_ff <= next_id_ff + 32'd1;
                  push_id_ff <= next_id_ff;
               end
               ACT_CLEAR: held_ff <= '0;
               default: ;
            endcase
         end

         if (state_ff == ST_PUSHCHK && int'(held_ff) <= lim) begin
            res_ff <= status_rsp(push_id_ff, sat5(8'(held_ff)), 1'b0);
         end

         if (state_ff == ST_COUNT && scan_done) begin
            total_ff <= cnt_ff;
            res_ff   <= status_rsp(32'd0, sat5(8'(cnt_ff)), 1'b0);
         end

         if (state_ff == ST_SELECT && scan_done && op_ff != ACT_PUSH) begin
            used_ff[best_idx_ff] <= 1'b1;
            k_ff                 <= k_ff + 5'd1;
            res_ff               <= entry_rsp(best_ff, sat5(8'(total_ff)), list_last);
         end

         if (state_ff == ST_FILTER && scan_done) begin
            held_ff <= wa_ff;
            res_ff  <= status_rsp(32'd0, sat5(8'((op_ff == ACT_DISM_CAT) ? cnt_ff : wa_ff)),
                                  found_ff);
         end
      end
   end

   assign req_port.ready = (state_ff == ST_IDLE);
   assign res_valid      = (state_ff == ST_EMIT);
   assign res_data       = res_ff;

   `PAT_ASSERT(a_held_bound, (state_ff == ST_IDLE) |-> (int'(held_ff) <= CAPACITY), "held exceeds capacity")
   `PAT_ASSERT(a_compact_below, (state_ff == ST_FILTER && ram_we) |-> (wa_ff <= d_idx_ff), "compaction write overtakes read")
   `PAT_ASSERT(a_list_pick, (state_ff == ST_SELECT && scan_done && op_ff != ACT_PUSH) |-> best_vld_ff, "listing pass found no entry")
   `PAT_ASSERT(a_evict_pick, (state_ff == ST_SELECT && scan_done && op_ff == ACT_PUSH) |-> best_vld_ff, "eviction pass found no victim")
endmodule

[rtl/core/priority_alert_table_unit.sv]
// Top level of the priority alert table: limit register, sequencer and response register.
// Depends on pat_pkg, pat_ifs and pat_ctrl.
//
//   port       dir   handshake        carries
//   req_port   in    valid/ready      one action with its operands
//   rsp_port   out   valid/ready      result items, last marks the final one
//   csr_*      in    csr_we           capacity limit
//
// A request is taken only while the sequencer is idle. Each pass over the slot RAM reads
// one slot per cycle. Push writes the new slot, then a check, plus two passes (select,
// filter) and a further check per eviction; tick and dismissals one filter pass; list one
// count pass plus one select pass and one emit state per listed entry.
// Reset is synchronous; the table comes up empty, no clearing pass.
// A stalled response holds in the output register while the next request is accepted;
// a second response waits in the sequencer, which then takes no request.
module priority_alert_table_unit
   import pat_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   pat_req_if.sink    req_port,
   pat_rsp_if.source  rsp_port,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata
);
   logic [4:0] cap_limit_ff;
   logic       res_valid, res_ready, rsp_valid_ff;
   rsp_type    res_data, rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_limit_ff <= 5'd16;
      end else if (csr_we) begin
         cap_limit_ff <= csr_wdata;
      end
   end

   pat_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .cap_limit(cap_limit_ff),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res_data (res_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.alert_id      = rsp_data_ff.alert_id;
   assign rsp_port.priority_out  = rsp_data_ff.priority_out;
   assign rsp_port.category_out  = rsp_data_ff.category_out;
   assign rsp_port.message_out   = rsp_data_ff.message_out;
   assign rsp_port.age_out       = rsp_data_ff.age_out;
   assign rsp_port.remaining_out = rsp_data_ff.remaining_out;
   assign rsp_port.match_count   = rsp_data_ff.match_count;
   assign rsp_port.found         = rsp_data_ff.found;
   assign rsp_port.entry_present = rsp_data_ff.entry_present;
   assign rsp_port.last          = rsp_data_ff.last;
endmodule

[bench/pat_table_checker.sv]
// Checker for the priority alert table unit: watches both channels and the limit register,
// predicts the result stream and compares it field by field.
// Depends on pat_pkg and pat_ifs.
module pat_table_checker
   import pat_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pat_req_if         req,
   pat_rsp_if         rsp,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata,
   output int         fail_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 16;

   entry_type   alerts_q[$];
   rsp_type     expected_q[$];
   logic [31:0] next_id;
   logic [4:0]  limit_reg;

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
      fail_count++;
   endtask

   function automatic logic [4:0] clamp_count(input int n);
      return (n > 31) ? 5'd31 : n[4:0];
   endfunction

   function automatic rsp_type blank_result();
      rsp_type r;
      r = '0;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic list_alerts(input logic by_cat, input logic [7:0] cat);
      bit      taken[$];
      int      total;
      int      best;
      int      emitted;
      rsp_type r;
      total = 0;
      emitted = 0;
      taken = {};
      foreach (alerts_q[i]) begin
         taken = {taken, 1'b0};
         if (alerts_q[i].rem != 0 && (!by_cat || alerts_q[i].cat == cat)) total++;
      end
      while (emitted < MAX_RESULTS) begin
         best = -1;
         foreach (alerts_q[i]) begin
            if (taken[i] || alerts_q[i].rem == 0) continue;
            if (by_cat && alerts_q[i].cat != cat) continue;
            if (best < 0 || alerts_q[i].pri > alerts_q[best].pri ||
                (alerts_q[i].pri == alerts_q[best].pri && alerts_q[i].age < alerts_q[best].age))
               best = i;
         end
         if (best < 0) break;
         taken[best] = 1'b1;
         r = '0;
         r.alert_id      = alerts_q[best].id;
         r.priority_out  = alerts_q[best].pri;
         r.category_out  = alerts_q[best].cat;
         r.message_out   = alerts_q[best].msg;
         r.age_out       = alerts_q[best].age;
         r.remaining_out = alerts_q[best].rem;
         r.match_count   = clamp_count(total);
         r.entry_present = 1'b1;
         expected_q = {expected_q, r};
         emitted++;
      end
      if (emitted == 0) expected_q = {expected_q, blank_result()};
      else expected_q[$].last = 1'b1;
   endtask

   task automatic predict_request();
      rsp_type   r;
      entry_type e;
      int        lim;
      int        w;
      int        n;
      int        sum;
      r = blank_result();
      case (action_type'(req.action))
         ACT_LIST:     list_alerts(1'b0, req.category_in);
         ACT_LIST_CAT: list_alerts(1'b1, req.category_in);
         ACT_PUSH: begin
            lim = (limit_reg == 0) ? 1 : (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
            e.id  = next_id;
            e.pri = req.priority_in;
            e.cat = req.category_in;
            e.msg = req.message_in;
            e.age = '0;
            e.rem = req.duration_ticks;
            alerts_q = {alerts_q, e};
            r.alert_id = next_id;
            next_id = next_id + 32'd1;
            // evict lowest priority, then oldest, then earliest pushed
            while (alerts_q.size() > lim) begin
               w = 0;
               for (int i = 1; i < alerts_q.size(); i++)
                  if (alerts_q[i].pri < alerts_q[w].pri ||
                      (alerts_q[i].pri == alerts_q[w].pri && alerts_q[i].age > alerts_q[w].age))
                     w = i;
               alerts_q.delete(w);
            end
            r.match_count = clamp_count(alerts_q.size());
         end
         ACT_TICK: begin
            foreach (alerts_q[i]) begin
               sum = alerts_q[i].age + req.delta_ticks;
               alerts_q[i].age = (sum > 16'hffff) ? 16'hffff : sum[15:0];
               alerts_q[i].rem = (alerts_q[i].rem > req.delta_ticks) ?
                                 alerts_q[i].rem - req.delta_ticks : 16'd0;
            end
            for (int i = alerts_q.size() - 1; i >= 0; i--)
               if (alerts_q[i].rem == 0) alerts_q.delete(i);
            r.match_count = clamp_count(alerts_q.size());
         end
         ACT_DISM_ID: begin
            foreach (alerts_q[i])
               if (alerts_q[i].id == req.target_id) begin
                  alerts_q.delete(i);
                  r.found = 1'b1;
                  break;
               end
            r.match_count = clamp_count(alerts_q.size());
         end
         ACT_DISM_CAT: begin
            n = 0;
            for (int i = alerts_q.size() - 1; i >= 0; i--)
               if (alerts_q[i].cat == req.category_in) begin
                  alerts_q.delete(i);
                  n++;
               end
            r.match_count = clamp_count(n);
         end
         ACT_CLEAR: alerts_q.delete();
         default: begin
            n = 0;
            foreach (alerts_q[i]) if (alerts_q[i].rem != 0) n++;
            r.match_count = clamp_count(n);
         end
      endcase
      case (action_type'(req.action)) inside
         ACT_LIST, ACT_LIST_CAT: ;
         default: expected_q = {expected_q, r};
      endcase
   endtask

   task automatic check_result();
      rsp_type w;
      if (expected_q.size() == 0) begin
         report("unexpected result", rsp.alert_id, 32'd0);
         return;
      end
      w = expected_q.pop_front();
      if (rsp.alert_id !== w.alert_id)
         report("alert_id", rsp.alert_id, w.alert_id);
      if (rsp.priority_out !== w.priority_out)
         report("priority_out", 32'(rsp.priority_out), 32'(w.priority_out));
      if (rsp.category_out !== w.category_out)
         report("category_out", 32'(rsp.category_out), 32'(w.category_out));
      if (rsp.message_out !== w.message_out)
         report("message_out", 32'(rsp.message_out), 32'(w.message_out));
      if (rsp.age_out !== w.age_out)
         report("age_out", 32'(rsp.age_out), 32'(w.age_out));
      if (rsp.remaining_out !== w.remaining_out)
         report("remaining_out", 32'(rsp.remaining_out), 32'(w.remaining_out));
      if (rsp.match_count !== w.match_count)
         report("match_count", 32'(rsp.match_count), 32'(w.match_count));
      if (rsp.found !== w.found)
         report("found", 32'(rsp.found), 32'(w.found));
      if (rsp.entry_present !== w.entry_present)
         report("entry_present", 32'(rsp.entry_present), 32'(w.entry_present));
      if (rsp.last !== w.last)
         report("last", 32'(rsp.last), 32'(w.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         alerts_q.delete();
         expected_q.delete();
         next_id = 32'd1;
         limit_reg = 5'd16;
         fail_count = 0;
      end else begin
         if (csr_we) limit_reg = csr_wdata;
         if (rsp.valid && rsp.ready) check_result();
         if (req.valid && req.ready) predict_request();
      end
      pending_count = expected_q.size();
   end

endmodule

[bench/tb_priority_alert_table_unit.sv]
// Testbench top for the priority alert table unit: clock, reset, request and limit stimulus,
// response stalls and the verdict. Depends on pat_pkg, pat_ifs and pat_table_checker.
module tb_priority_alert_table_unit;
   import pat_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      action_type  act;
      logic [1:0]  pri;
      logic [7:0]  cat;
      logic [15:0] msg;
      logic [15:0] dur;
      logic [15:0] delta;
      logic [31:0] target;
   } request_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [4:0] csr_wdata;
   logic       hold_rsp;
   logic       calm_rsp;
   int         fail_count;
   int         pending_count;
   int         pushes_sent;

   pat_req_if req_port ();
   pat_rsp_if rsp_port ();

   priority_alert_table_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .rsp_port  (rsp_port),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   pat_table_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req           (req_port),
      .rsp           (rsp_port),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random stalls, quiet stretches, and a long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_port.ready <= 1'b0;
      else rsp_port.ready <= !hold_rsp && (calm_rsp || $urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (reset) calm_rsp <= 1'b0;
      else if ($urandom_range(0, 63) == 0) calm_rsp <= !calm_rsp;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic request_type make_request(input action_type act);
      request_type q;
      q.act    = act;
      q.pri    = 2'($urandom_range(0, 3));
      q.cat    = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3));
      q.msg    = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
         0:       q.dur = 16'd0;
         1:       q.dur = 16'hffff;
         2:       q.dur = 16'($urandom_range(0, 65535));
         default: q.dur = 16'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 9))
         0:       q.delta = 16'hffff;
         1:       q.delta = 16'($urandom_range(0, 65535));
         default: q.delta = 16'($urandom_range(0, 8));
      endcase
      if ($urandom_range(0, 5) == 0) q.target = 32'($urandom);
      else q.target = 32'(pushes_sent + 1 - int'($urandom_range(0, 20)));
      return q;
   endfunction

   function automatic action_type pick_action();
      case ($urandom_range(0, 19)) inside
         [0:7]:   return ACT_PUSH;
         [8:9]:   return ACT_TICK;
         [10:11]: return ACT_DISM_ID;
         12:      return ACT_DISM_CAT;
         13:      return ACT_CLEAR;
         [14:15]: return ACT_LIST;
         [16:17]: return ACT_LIST_CAT;
         default: return ACT_COUNT;
      endcase
   endfunction

   // drive one request and hold it until the unit takes it
   task automatic send(input request_type q);
      logic taken;
      req_port.valid          <= 1'b1;
      req_port.action         <= q.act;
      req_port.priority_in    <= q.pri;
      req_port.category_in    <= q.cat;
      req_port.message_in     <= q.msg;
      req_port.duration_ticks <= q.dur;
      req_port.delta_ticks    <= q.delta;
      req_port.target_id      <= q.target;
      if (q.act == ACT_PUSH) pushes_sent++;
      do begin
         @(negedge clock);
         taken = req_port.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic send_random(input int count);
      int burst;
      burst = 0;
      for (int k = 0; k < count; k++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 8);
            if ($urandom_range(0, 2) != 0) begin
               req_port.valid <= 1'b0;
               repeat ($urandom_range(1, 20)) @(posedge clock);
            end
         end
         send(make_request(pick_action()));
         burst--;
      end
      req_port.valid <= 1'b0;
   endtask

   // stop offering and wait for every result still owed
   task automatic drain();
      req_port.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_limit(input logic [4:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_directed(input action_type act, input logic [1:0] pri, input logic [7:0] cat,
                                input logic [15:0] msg, input logic [15:0] dur,
                                input logic [15:0] delta, input logic [31:0] target);
      request_type q;
      q.act = act; q.pri = pri; q.cat = cat; q.msg = msg;
      q.dur = dur; q.delta = delta; q.target = target;
      send(q);
   endtask

   initial begin
      logic [4:0] limits[7];
      limits = '{5'd31, 5'd3, 5'd1, 5'd0, 5'd8, 5'd17, 5'd16};
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      hold_rsp <= 1'b0;
      req_port.valid <= 1'b0;
      req_port.action <= ACT_COUNT;
      req_port.priority_in <= '0;
      req_port.category_in <= '0;
      req_port.message_in <= '0;
      req_port.duration_ticks <= '0;
      req_port.delta_ticks <= '0;
      req_port.target_id <= '0;
      pushes_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty listings, field extremes, saturation, dismissals
      send_directed(ACT_LIST,     2'd0, 8'd0,   16'h0000, 16'd0,    16'd0,    32'd0);
      send_directed(ACT_LIST_CAT, 2'd0, 8'd255, 16'h0000, 16'd0,    16'd0,    32'd0);
      send_directed(ACT_PUSH,     2'd0, 8'd0,   16'h0000, 16'd0,    16'd0,    32'd0);
      send_directed(ACT_COUNT,    2'd0, 8'd0,   16'h0000, 16'd0,    16'd0,    32'd0);
      send_directed(ACT_PUSH,     2'd3, 8'd255, 16'hffff, 16'hffff, 16'd0,    32'd0);
      send_directed(ACT_PUSH,     2'd1, 8'd7,   16'h5a5a, 16'd5,    16'd0,    32'd0);
      send_directed(ACT_PUSH,     2'd2, 8'd7,   16'ha5a5, 16'd10,   16'd0,    32'd0);
      send_directed(ACT_PUSH,     2'd2, 8'd7,   16'h1234, 16'd10,   16'd0,    32'd0);
      send_directed(ACT_LIST,     2'd0, 8'd0,   16'h0000, 16'd0,    16'd0,    32'd0);
      send_directed(ACT_TICK,     2'd0, 8'd0,   16'h0000, 16'd0,    16'd1,    32'd0);
      send_directed(ACT_PUSH,     2'd2, 8'd9,   16'hbeef, 16'd3,    16'd0,    32'd0);
      send_directed(ACT_LIST,     2'd0, 8'd0,   16'h0000, 16'd0,    16'd0,    32'd0);
      send_directed(ACT_LIST_CAT, 2'd0, 8'd7,   16'h0000, 16'd0,    16'd0,    32'd0);
      send_directed(ACT_DISM_ID,  2'd0, 8'd0,   16'h0000, 16'd0,    16'd0,    32'd3);
      send_directed(ACT_DISM_ID,  2'd0, 8'd0,   16'h0000, 16'd0,    16'd0,    32'hffffffff);
      send_directed(ACT_DISM_CAT, 2'd0, 8'd7,   16'h0000, 16'd0,    16'd0,    32'd0);
      send_directed(ACT_TICK,     2'd0, 8'd0,   16'h0000, 16'd0,    16'hffff, 32'd0);
      send_directed(ACT_PUSH,     2'd1, 8'd1,   16'h0001, 16'd20,   16'd0,    32'd0);
      send_directed(ACT_TICK,     2'd0, 8'd0,   16'h0000, 16'd0,    16'd0,    32'd0);
      send_directed(ACT_COUNT,    2'd0, 8'd0,   16'h0000, 16'd0,    16'd0,    32'd0);
      send_directed(ACT_CLEAR,    2'd0, 8'd0,   16'h0000, 16'd0,    16'd0,    32'd0);
      send_directed(ACT_LIST,     2'd0, 8'd0,   16'h0000, 16'd0,    16'd0,    32'd0);

      // fill past the default limit, then lower it and push once more
      for (int k = 0; k < 18; k++) send(make_request(ACT_PUSH));
      send_directed(ACT_LIST, 2'd0, 8'd0, 16'h0000, 16'd0, 16'd0, 32'd0);
      write_limit(5'd2);
      send_directed(ACT_COUNT, 2'd0, 8'd0, 16'h0000, 16'd0, 16'd0, 32'd0);
      send(make_request(ACT_PUSH));
      send_directed(ACT_LIST, 2'd0, 8'd0, 16'h0000, 16'd0, 16'd0, 32'd0);

      // long receiver hold-off while the sender keeps offering
      write_limit(5'd16);
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         send_random(20);
      join

      foreach (limits[i]) begin
         write_limit(limits[i]);
         send_random(20);
      end

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
